>>> src/lbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes for the buffer cache tag block: request and result
// layouts, per-buffer update bundle and the victim search carry.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam logic [1:0] OP_GET        = 2'd0;
    localparam logic [1:0] OP_RELEASE    = 2'd1;
    localparam logic [1:0] OP_MARK_DIRTY = 2'd2;
    localparam logic [1:0] OP_SYNC       = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_PINNED = 2'd2;

    localparam logic [31:0] LIMIT_RESET = 32'd64;
    localparam logic [15:0] PIN_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] block_number;
        logic [2:0]  buffer_index;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] disk_block;
        logic [2:0]  slot;
        logic [1:0]  status;
        logic        was_hit;
        logic [3:0]  flush_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        inc_pin;
        logic        dec_pin;
        logic        set_dirty;
        logic        clean;
        logic        load;
        logic        stamp_en;
        logic [31:0] blk;
        logic [31:0] stamp;
    } cell_act_t;

    typedef struct packed {
        logic        hit;
        logic        have;
        logic        inv;
        logic        wb;
        logic [31:0] stamp;
        logic [31:0] blk;
    } scan_t;

endpackage
`default_nettype wire

>>> src/lru_buffer_cache_tags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_buffer_cache_tags
// Tag state of a small block buffer cache with pin counts and LRU victims.
// Release, mark-dirty, out-of-range get: done strobe in the next cycle, no busy.
// Get: the search wave moves one cell per cycle; a hit or all pinned gives DONE,
// a clean victim gives READ then DONE, a dirty victim gives WRITE, READ, DONE.
// Sync: one buffer visited per cycle, a WRITE result for each dirty one, then DONE.
// Reset: all buffers invalid, clean, unpinned; use clock 0; limit 64.
// ----------------------------------------------------------------------------
module lru_buffer_cache_tags #(
    parameter int BUFFERS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire lbc_pkg::request_t request,
    output lbc_pkg::result_t       result,
    output logic                   result_valid,
    input  wire logic              limit_we,
    input  wire logic [31:0]       limit_data
);
    import lbc_pkg::*;

    localparam int IW = $clog2(BUFFERS);
    localparam int CW = $clog2(BUFFERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH,
        S_SYNC,
        S_SYNC_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [31:0]   limit_reg, limit_next;
    logic [31:0]   clock_reg, clock_next;
    logic [31:0]   req_blk_reg, req_blk_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] flush_reg, flush_next;
    result_t       result_reg, result_next;
    logic          strobe_reg, strobe_next;

    scan_t         chain [BUFFERS];
    logic [IW-1:0] hit_idx [BUFFERS];
    logic [IW-1:0] cand_idx [BUFFERS];
    logic          vd [BUFFERS];
    logic [31:0]   blk [BUFFERS];
    logic [BUFFERS-1:0] sel;

    cell_act_t     act;
    logic          act_en;
    logic [IW-1:0] target;
    logic          in_range;
    scan_t         tail;

    assign tail     = chain[BUFFERS-1];
    assign in_range = 32'(request.buffer_index) < 32'(BUFFERS);

    genvar k;
    generate
        for (k = 0; k < BUFFERS; k++)
        begin : g_cell
            assign sel[k] = act_en && (target == IW'(k));
            if (k == 0)
            begin : g_head
                lbc_cell #(
                    .INDEX (k),
                    .IW    (IW)
                ) u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .sel          (sel[k]),
                    .act          (act),
                    .req_blk      (req_blk_reg),
                    .scan_in      ('0),
                    .hit_idx_in   ('0),
                    .cand_idx_in  ('0),
                    .scan_out     (chain[k]),
                    .hit_idx_out  (hit_idx[k]),
                    .cand_idx_out (cand_idx[k]),
                    .vd           (vd[k]),
                    .blk          (blk[k])
                );
            end
            else
            begin : g_body
                lbc_cell #(
                    .INDEX (k),
                    .IW    (IW)
                ) u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .sel          (sel[k]),
                    .act          (act),
                    .req_blk      (req_blk_reg),
                    .scan_in      (chain[k-1]),
                    .hit_idx_in   (hit_idx[k-1]),
                    .cand_idx_in  (cand_idx[k-1]),
                    .scan_out     (chain[k]),
                    .hit_idx_out  (hit_idx[k]),
                    .cand_idx_out (cand_idx[k]),
                    .vd           (vd[k]),
                    .blk          (blk[k])
                );
            end
        end
    endgenerate

    // buffer update for this cycle
    always_comb
    begin
        act       = '0;
        act.blk   = req_blk_reg;
        act.stamp = clock_reg + 32'd1;
        act_en    = 1'b0;
        target    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (request.opcode)
                        OP_RELEASE:
                        begin
                            act.dec_pin = 1'b1;
                            act_en      = in_range;
                            target      = IW'(request.buffer_index);
                        end
                        OP_MARK_DIRTY:
                        begin
                            act.set_dirty = 1'b1;
                            act_en        = in_range;
                            target        = IW'(request.buffer_index);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CW'(BUFFERS) && tail.hit)
                begin
                    act.inc_pin  = 1'b1;
                    act.stamp_en = 1'b1;
                    act_en       = 1'b1;
                    target       = hit_idx[BUFFERS-1];
                end
            end
            S_FINISH:
            begin
                act.load     = 1'b1;
                act.stamp_en = 1'b1;
                act_en       = 1'b1;
                target       = idx_reg;
            end
            S_SYNC:
            begin
                act.clean = 1'b1;
                act_en    = vd[idx_reg];
                target    = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        limit_next   = limit_we ? limit_data : limit_reg;
        clock_next   = clock_reg;
        req_blk_next = req_blk_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        flush_next   = flush_reg;
        result_next  = '0;
        strobe_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (request.opcode)
                        OP_GET:
                        begin
                            if (request.block_number >= limit_reg)
                            begin
                                result_next.kind   = KIND_DONE;
                                result_next.status = STATUS_RANGE;
                                result_next.last   = 1'b1;
                                strobe_next        = 1'b1;
                            end
                            else
                            begin
                                req_blk_next = request.block_number;
                                cnt_next     = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        OP_RELEASE, OP_MARK_DIRTY:
                        begin
                            result_next.kind = KIND_DONE;
                            result_next.slot = request.buffer_index;
                            result_next.last = 1'b1;
                            strobe_next      = 1'b1;
                        end
                        default:
                        begin
                            idx_next   = '0;
                            flush_next = '0;
                            state_next = S_SYNC;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CW'(BUFFERS))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    strobe_next = 1'b1;
                    priority if (tail.hit)
                    begin
                        result_next.kind    = KIND_DONE;
                        result_next.slot    = 3'(hit_idx[BUFFERS-1]);
                        result_next.was_hit = 1'b1;
                        result_next.last    = 1'b1;
                        clock_next          = clock_reg + 32'd1;
                        state_next          = S_IDLE;
                    end
                    else if (!tail.have)
                    begin
                        result_next.kind   = KIND_DONE;
                        result_next.status = STATUS_PINNED;
                        result_next.last   = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else if (tail.wb)
                    begin
                        idx_next               = cand_idx[BUFFERS-1];
                        result_next.kind       = KIND_WRITE;
                        result_next.disk_block = tail.blk;
                        result_next.slot       = 3'(cand_idx[BUFFERS-1]);
                        state_next             = S_READ;
                    end
                    else
                    begin
                        idx_next               = cand_idx[BUFFERS-1];
                        result_next.kind       = KIND_READ;
                        result_next.disk_block = req_blk_reg;
                        result_next.slot       = 3'(cand_idx[BUFFERS-1]);
                        state_next             = S_FINISH;
                    end
                end
            end
            S_READ:
            begin
                result_next.kind       = KIND_READ;
                result_next.disk_block = req_blk_reg;
                result_next.slot       = 3'(idx_reg);
                strobe_next            = 1'b1;
                state_next             = S_FINISH;
            end
            S_FINISH:
            begin
                result_next.kind = KIND_DONE;
                result_next.slot = 3'(idx_reg);
                result_next.last = 1'b1;
                strobe_next      = 1'b1;
                clock_next       = clock_reg + 32'd1;
                state_next       = S_IDLE;
            end
            S_SYNC:
            begin
                if (vd[idx_reg])
                begin
                    result_next.kind       = KIND_WRITE;
                    result_next.disk_block = blk[idx_reg];
                    result_next.slot       = 3'(idx_reg);
                    strobe_next            = 1'b1;
                    flush_next             = flush_reg + CW'(1);
                end
                if (idx_reg == IW'(BUFFERS - 1))
                begin
                    state_next = S_SYNC_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SYNC_DONE:
            begin
                result_next.kind        = KIND_DONE;
                result_next.flush_count = 4'(flush_reg);
                result_next.last        = 1'b1;
                strobe_next             = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limit_reg   <= LIMIT_RESET;
            clock_reg   <= '0;
            req_blk_reg <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            flush_reg   <= '0;
            result_reg  <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            clock_reg   <= clock_next;
            req_blk_reg <= req_blk_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            flush_reg   <= flush_next;
            result_reg  <= result_next;
            strobe_reg  <= strobe_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = strobe_reg;

endmodule
`default_nettype wire

>>> src/lbc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_cell
// One buffer's tag state plus one stage of the hit / victim search chain.
// ----------------------------------------------------------------------------
module lbc_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sel,
    input  wire lbc_pkg::cell_act_t act,
    input  wire logic [31:0]        req_blk,
    input  wire lbc_pkg::scan_t     scan_in,
    input  wire logic [IW-1:0]      hit_idx_in,
    input  wire logic [IW-1:0]      cand_idx_in,
    output lbc_pkg::scan_t          scan_out,
    output logic [IW-1:0]           hit_idx_out,
    output logic [IW-1:0]           cand_idx_out,
    output logic                    vd,
    output logic [31:0]             blk
);
    import lbc_pkg::*;

    logic          valid_reg, valid_next;
    logic          dirty_reg, dirty_next;
    logic [15:0]   pin_reg, pin_next;
    logic [31:0]   blk_reg, blk_next;
    logic [31:0]   stamp_reg, stamp_next;
    scan_t         scan_reg, scan_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] cand_idx_reg, cand_idx_next;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        pin_next   = pin_reg;
        blk_next   = blk_reg;
        stamp_next = stamp_reg;
        if (sel)
        begin
            if (act.load)
            begin
                valid_next = 1'b1;
                dirty_next = 1'b0;
                pin_next   = 16'd1;
                blk_next   = act.blk;
            end
            if (act.inc_pin && pin_reg != PIN_MAX)
            begin
                pin_next = pin_reg + 16'd1;
            end
            if (act.dec_pin && pin_reg != 16'd0)
            begin
                pin_next = pin_reg - 16'd1;
            end
            if (act.set_dirty)
            begin
                dirty_next = 1'b1;
            end
            if (act.clean)
            begin
                dirty_next = 1'b0;
            end
            if (act.stamp_en)
            begin
                stamp_next = act.stamp;
            end
        end
    end

    // hit check and victim check of this one search stage
    always_comb
    begin
        scan_next     = scan_in;
        hit_idx_next  = hit_idx_in;
        cand_idx_next = cand_idx_in;
        if (!scan_in.hit && valid_reg && blk_reg == req_blk)
        begin
            scan_next.hit = 1'b1;
            hit_idx_next  = IW'(INDEX);
        end
        priority if (scan_in.inv)
        begin
            scan_next.inv = 1'b1;
        end
        else if (!valid_reg)
        begin
            scan_next.inv   = 1'b1;
            scan_next.have  = 1'b1;
            scan_next.wb    = 1'b0;
            scan_next.stamp = stamp_reg;
            scan_next.blk   = blk_reg;
            cand_idx_next   = IW'(INDEX);
        end
        else if (pin_reg == 16'd0 && (!scan_in.have || stamp_reg < scan_in.stamp))
        begin
            scan_next.have  = 1'b1;
            scan_next.wb    = dirty_reg;
            scan_next.stamp = stamp_reg;
            scan_next.blk   = blk_reg;
            cand_idx_next   = IW'(INDEX);
        end
        else
        begin
            scan_next.have = scan_in.have;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            dirty_reg    <= 1'b0;
            pin_reg      <= '0;
            blk_reg      <= '0;
            stamp_reg    <= '0;
            scan_reg     <= '0;
            hit_idx_reg  <= '0;
            cand_idx_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            pin_reg      <= pin_next;
            blk_reg      <= blk_next;
            stamp_reg    <= stamp_next;
            scan_reg     <= scan_next;
            hit_idx_reg  <= hit_idx_next;
            cand_idx_reg <= cand_idx_next;
        end
    end

    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign cand_idx_out = cand_idx_reg;
    assign vd           = valid_reg & dirty_reg;
    assign blk          = blk_reg;

endmodule
`default_nettype wire
